### src/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types, constants and helpers for the matrix multiply with snapping.
// ----------------------------------------------------------------------------
package mms_pkg;

    localparam int DEF_MAX_DIM     = 8;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DIM_W           = 4;
    localparam int CFG_ADDR_W      = 4;
    localparam int FRAC_DROP       = 16;

    // snap thresholds, accumulator has 32 fraction bits
    localparam logic [63:0] SNAP_ONE_LOW  = 64'd4252017624;
    localparam logic [63:0] SNAP_ONE      = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SNAP_ZERO_MAG = 64'd4294967;

    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [31:0] elem_value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] prod_value;
        logic [2:0]         prod_row;
        logic [2:0]         prod_col;
        logic               last_elem;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic issue;
        logic snap;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
    } t_mac_stat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input int max_dim);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > max_dim) begin
            res = DIM_W'(max_dim);
        end
        return res;
    endfunction

endpackage

### src/matrix_multiply_snap_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_snap_top
// Load words are accepted only while idle. A compute word gives
// rows_a*cols_b product words, one after another on the single shared MAC
// (one store read per inner step, then pipeline drain, snap and output).
// Sync active-low reset clears control and sets the dimensions to 8 (clamped
// to MAX_DIM); the matrix stores are not cleared, and the user must write
// them before they are read, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module matrix_multiply_snap_top import mms_pkg::*; #(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_word              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_word             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int CMP_W  = CNT_W + DIM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_SNAP,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_row, n_row, r_col, n_col, r_k, n_k;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_data, n_out_data;
    logic [DIM_W-1:0]       r_rows_a, r_inner, r_cols_b;
    logic                   w_in_acc, w_cfg_wr, w_in_range, w_out_free;
    logic                   w_we_a, w_we_b;
    logic                   w_k_last, w_row_last, w_col_last;
    logic [ADDR_W-1:0]      w_waddr, w_raddr_a, w_raddr_b;
    logic [VALUE_WIDTH-1:0] w_wdata, w_a_data, w_b_data, w_value;
    logic [CNT_W+2:0]       w_row_ext, w_col_ext;
    t_mac_ctl               w_ctl;
    t_mac_stat              w_stat;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= clamp_dim(DIM_W'(8), MAX_DIM);
            r_inner  <= clamp_dim(DIM_W'(8), MAX_DIM);
            r_cols_b <= clamp_dim(DIM_W'(8), MAX_DIM);
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_ROWS_A:    r_rows_a <= clamp_dim(pwdata[DIM_W-1:0], MAX_DIM);
                REG_INNER_DIM: r_inner  <= clamp_dim(pwdata[DIM_W-1:0], MAX_DIM);
                REG_COLS_B:    r_cols_b <= clamp_dim(pwdata[DIM_W-1:0], MAX_DIM);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROWS_A:    prdata = 32'(r_rows_a);
            REG_INNER_DIM: prdata = 32'(r_inner);
            REG_COLS_B:    prdata = 32'(r_cols_b);
            default:       prdata = '0;
        endcase
    end

    // element loads
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_in_range = (int'(i_in_data.row_index) < MAX_DIM)
                      && (int'(i_in_data.col_index) < MAX_DIM);
    assign w_we_a     = w_in_acc && w_in_range && (i_in_data.op == OP_LOAD_A);
    assign w_we_b     = w_in_acc && w_in_range && (i_in_data.op == OP_LOAD_B);
    assign w_waddr    = ADDR_W'(int'(i_in_data.row_index) * MAX_DIM
                              + int'(i_in_data.col_index));
    assign w_wdata    = VALUE_WIDTH'($unsigned(i_in_data.elem_value));

    assign w_raddr_a  = ADDR_W'(int'(r_row) * MAX_DIM + int'(r_k));
    assign w_raddr_b  = ADDR_W'(int'(r_k) * MAX_DIM + int'(r_col));

    mms_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_a),
        .o_rdata (w_a_data)
    );

    mms_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_b),
        .o_rdata (w_b_data)
    );

    assign w_ctl.issue = (r_state == S_ISSUE);
    assign w_ctl.clear = (r_state == S_ISSUE) && (r_k == '0);
    assign w_ctl.snap  = (r_state == S_SNAP);

    mms_mac #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_a_data (w_a_data),
        .i_b_data (w_b_data),
        .o_stat   (w_stat),
        .o_value  (w_value)
    );

    // sequencer
    assign w_k_last   = (CMP_W'(r_k) + 1'b1) == CMP_W'(r_inner);
    assign w_row_last = (CMP_W'(r_row) + 1'b1) == CMP_W'(r_rows_a);
    assign w_col_last = (CMP_W'(r_col) + 1'b1) == CMP_W'(r_cols_b);
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_row_ext  = {3'b000, r_row};
    assign w_col_ext  = {3'b000, r_col};

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_k         = r_k;
        n_out_valid = r_out_valid & i_out_stall;
        n_out_data  = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_data.op == OP_COMPUTE)) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_k_last) begin
                    n_k     = '0;
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!w_stat.busy) begin
                    n_state = S_SNAP;
                end
            end
            S_SNAP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_data.prod_value = 32'(w_value);
                    n_out_data.prod_row   = w_row_ext[2:0];
                    n_out_data.prod_col   = w_col_ext[2:0];
                    n_out_data.last_elem  = w_row_last & w_col_last;
                    if (w_row_last && w_col_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ISSUE;
                        if (w_col_last) begin
                            n_col = '0;
                            n_row = r_row + 1'b1;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
            r_out_data  <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("output word loaded outside emit");

    a_busy_in_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> (r_state == S_ISSUE || r_state == S_DRAIN))
        else $error("mac pipeline active outside issue and drain");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && w_row_last && w_col_last)
        |=> r_state == S_IDLE)
        else $error("run did not end after last word");

    a_k_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_ISSUE |-> r_k == '0)
        else $error("inner counter not parked");
`endif

endmodule

### src/mms_ram.sv
// ----------------------------------------------------------------------------
// mms_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mms_mac.sv
// ----------------------------------------------------------------------------
// mms_mac
// Shared multiply-accumulate unit: split multiply, product sum, wide
// accumulator, snap and saturation to the output format.
// ----------------------------------------------------------------------------
module mms_mac import mms_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mac_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_a_data,
    input  logic [VALUE_WIDTH-1:0] i_b_data,
    output t_mac_stat              o_stat,
    output logic [VALUE_WIDTH-1:0] o_value
);

    localparam int HALF_W = (VALUE_WIDTH + 1) / 2;
    localparam int HIGH_W = VALUE_WIDTH - HALF_W;
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int ACC_W  = PROD_W + 4;
    localparam int Q_W    = ACC_W - FRAC_DROP;

    localparam logic signed [ACC_W-1:0] C_ONE_LOW  = ACC_W'(SNAP_ONE_LOW);
    localparam logic signed [ACC_W-1:0] C_ONE      = ACC_W'(SNAP_ONE);
    localparam logic signed [ACC_W-1:0] C_ZERO_POS = ACC_W'(SNAP_ZERO_MAG);
    localparam logic signed [ACC_W-1:0] C_ZERO_NEG = -C_ZERO_POS;
    localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
    localparam logic signed [Q_W-1:0]   Q_MIN = ~Q_MAX;

    logic signed [HIGH_W-1:0]        w_a_hi, w_b_hi;
    logic [HALF_W-1:0]               w_a_lo, w_b_lo;
    logic signed [HALF_W:0]          w_a_lo_s, w_b_lo_s;
    logic signed [2*HIGH_W-1:0]      r_pp_hh;
    logic signed [VALUE_WIDTH:0]     r_pp_hl, r_pp_lh;
    logic [2*HALF_W-1:0]             r_pp_ll;
    logic signed [PROD_W-1:0]        w_hh_ext, w_hl_ext, w_lh_ext;
    logic [PROD_W-1:0]               w_ll_ext;
    logic signed [PROD_W-1:0]        n_prod, r_prod;
    logic signed [ACC_W-1:0]         r_acc, n_snap, r_snap;
    logic signed [Q_W-1:0]           w_q;
    logic                            r_rd_v, r_mul_v, r_sum_v;

    // split operands into signed high and unsigned low halves
    assign w_a_hi   = i_a_data[VALUE_WIDTH-1:HALF_W];
    assign w_b_hi   = i_b_data[VALUE_WIDTH-1:HALF_W];
    assign w_a_lo   = i_a_data[HALF_W-1:0];
    assign w_b_lo   = i_b_data[HALF_W-1:0];
    assign w_a_lo_s = {1'b0, w_a_lo};
    assign w_b_lo_s = {1'b0, w_b_lo};

    assign w_hh_ext = r_pp_hh;
    assign w_hl_ext = r_pp_hl;
    assign w_lh_ext = r_pp_lh;
    assign w_ll_ext = PROD_W'(r_pp_ll);
    assign n_prod   = (w_hh_ext <<< (2 * HALF_W)) + ((w_hl_ext + w_lh_ext) <<< HALF_W)
                    + w_ll_ext;

    always_comb begin
        n_snap = r_acc;
        if (r_acc >= C_ONE_LOW && r_acc < C_ONE) begin
            n_snap = C_ONE;
        end else if (r_acc <= C_ZERO_POS && r_acc >= C_ZERO_NEG) begin
            n_snap = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
            r_sum_v <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_rd_v  <= i_ctl.issue;
            r_mul_v <= r_rd_v;
            r_sum_v <= r_mul_v;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_sum_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_pp_hh <= w_a_hi * w_b_hi;
            r_pp_hl <= w_a_hi * w_b_lo_s;
            r_pp_lh <= w_a_lo_s * w_b_hi;
            r_pp_ll <= w_a_lo * w_b_lo;
        end
        if (r_mul_v) begin
            r_prod <= n_prod;
        end
        if (i_ctl.snap) begin
            r_snap <= n_snap;
        end
    end

    // floor to 16 fraction bits, then saturate
    assign w_q = r_snap[ACC_W-1:FRAC_DROP];

    always_comb begin
        if (w_q > Q_MAX) begin
            o_value = Q_MAX[VALUE_WIDTH-1:0];
        end else if (w_q < Q_MIN) begin
            o_value = Q_MIN[VALUE_WIDTH-1:0];
        end else begin
            o_value = w_q[VALUE_WIDTH-1:0];
        end
    end

    assign o_stat.busy = r_rd_v | r_mul_v | r_sum_v;

endmodule
